// File: hw/rtl/compacting_list_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for compacting_list_table_core
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_LIST_TABLE_CORE_ASSERT_SVH
`define COMPACTING_LIST_TABLE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Types, codes and defaults shared by the compacting list table.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned DATA_W       = 64;

	// Action codes as seen on the command port
	localparam logic [2:0] ACT_APPEND    = 3'd0;
	localparam logic [2:0] ACT_REM_FIRST = 3'd1;
	localparam logic [2:0] ACT_REM_ALL   = 3'd2;
	localparam logic [2:0] ACT_WRITE     = 3'd3;
	localparam logic [2:0] ACT_DUMP      = 3'd4;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_REM_FIRST,
		OP_REM_ALL,
		OP_WRITE,
		OP_DUMP,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DUMP
	} back_state_t;

	typedef struct packed {
		logic [2:0]        action;
		logic [DATA_W-1:0] value;
		logic [5:0]        index;
	} in_t;

	typedef struct packed {
		logic [DATA_W-1:0] element;
		logic              is_last;
		status_t           status;
		logic [6:0]        count;
		logic [6:0]        removed;
	} out_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] value;
		logic [5:0]        index;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_link_t;

endpackage

`default_nettype wire

// File: hw/rtl/clt_ram.sv
// ----------------------------------------------------------------------------
// clt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// Command intake: decodes the action and holds commands in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire clt_pkg::in_t    cmd,
	output      logic            busy,
	input  wire logic            pop,
	output      clt_pkg::q_link_t q_out
);

	localparam int unsigned QDEPTH = 2;

	logic [1:0]       fill_q;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	clt_pkg::q_item_t buf_q [QDEPTH];
	clt_pkg::q_item_t item_in;
	logic             push;
	logic             pop_ok;

	assign busy   = (fill_q == 2'(QDEPTH));
	assign push   = start && !busy;
	assign pop_ok = pop && (fill_q != 2'd0);

	always_comb begin
		item_in.value = cmd.value;
		item_in.index = cmd.index;
		unique case (cmd.action)
			clt_pkg::ACT_APPEND:    item_in.op = clt_pkg::OP_APPEND;
			clt_pkg::ACT_REM_FIRST: item_in.op = clt_pkg::OP_REM_FIRST;
			clt_pkg::ACT_REM_ALL:   item_in.op = clt_pkg::OP_REM_ALL;
			clt_pkg::ACT_WRITE:     item_in.op = clt_pkg::OP_WRITE;
			clt_pkg::ACT_DUMP:      item_in.op = clt_pkg::OP_DUMP;
			default:                item_in.op = clt_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= item_in;
		end
	end

	assign q_out.valid = (fill_q != 2'd0);
	assign q_out.item  = buf_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: hw/rtl/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// Command execution: list store, compaction scan, dump stream, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_back #(
	parameter int unsigned CAPACITY = clt_pkg::CAPACITY_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire clt_pkg::q_link_t q_in,
	output      logic             pop,
	output      logic             valid,
	output      clt_pkg::out_t    result
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	clt_pkg::back_state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rd_q, rd_d;
	logic [CW-1:0] wr_q, wr_d;
	logic [CW-1:0] gone_q, gone_d;
	logic [CW-1:0] count_inc, rd_inc, wr_inc, gone_inc;
	logic [clt_pkg::DATA_W-1:0] val_q, val_d;
	logic          all_q, all_d;
	logic          vld_s1;
	logic          last_s1;
	clt_pkg::out_t res_q, res_d;
	logic          res_vld_q, res_vld_d;

	logic                       we, re;
	logic [AW-1:0]              waddr, raddr;
	logic [clt_pkg::DATA_W-1:0] wdata, rdata;

	assign count_inc = count_q + 1'b1;
	assign rd_inc    = rd_q + 1'b1;
	assign wr_inc    = wr_q + 1'b1;
	assign gone_inc  = gone_q + 1'b1;

	clt_ram #(
		.WIDTH (clt_pkg::DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rd_d      = rd_q;
		wr_d      = wr_q;
		gone_d    = gone_q;
		val_d     = val_q;
		all_d     = all_q;
		pop       = 1'b0;
		we        = 1'b0;
		waddr     = count_q[AW-1:0];
		wdata     = q_in.item.value;
		re        = 1'b0;
		raddr     = rd_q[AW-1:0];
		res_vld_d = 1'b0;
		res_d.element = '0;
		res_d.is_last = 1'b1;
		res_d.status  = clt_pkg::ST_OK;
		res_d.count   = 7'(count_q);
		res_d.removed = 7'd0;

		unique case (state_q)
			clt_pkg::B_IDLE: begin
				if (q_in.valid) begin
					pop = 1'b1;
					unique case (q_in.item.op)
						clt_pkg::OP_APPEND: begin
							res_vld_d = 1'b1;
							if (count_q == CW'(CAPACITY)) begin
								res_d.status = clt_pkg::ST_FULL;
							end else begin
								we          = 1'b1;
								count_d     = count_inc;
								res_d.count = 7'(count_inc);
							end
						end
						clt_pkg::OP_WRITE: begin
							res_vld_d = 1'b1;
							if (7'(q_in.item.index) < 7'(count_q)) begin
								we    = 1'b1;
								waddr = q_in.item.index[AW-1:0];
							end else begin
								res_d.status = clt_pkg::ST_RANGE;
							end
						end
						clt_pkg::OP_REM_FIRST, clt_pkg::OP_REM_ALL: begin
							val_d   = q_in.item.value;
							all_d   = (q_in.item.op == clt_pkg::OP_REM_ALL);
							rd_d    = '0;
							wr_d    = '0;
							gone_d  = '0;
							state_d = clt_pkg::B_SCAN;
						end
						clt_pkg::OP_DUMP: begin
							if (count_q == '0) begin
								res_vld_d = 1'b1;
							end else begin
								rd_d    = '0;
								state_d = clt_pkg::B_DUMP;
							end
						end
						clt_pkg::OP_NOP: begin
							res_vld_d = 1'b1;
						end
						default: begin
							res_vld_d = 1'b1;
						end
					endcase
				end
			end
			clt_pkg::B_SCAN: begin
				re = (rd_q < count_q);
				if (re) begin
					rd_d = rd_inc;
				end
				// read data arrives in the cycle after its address; keep survivors packed at wr_q
				if (vld_s1) begin
					if (rdata == val_q && (all_q || gone_q == '0)) begin
						gone_d = gone_inc;
					end else begin
						we    = 1'b1;
						waddr = wr_q[AW-1:0];
						wdata = rdata;
						wr_d  = wr_inc;
					end
				end
				if (!re && !vld_s1) begin
					count_d       = wr_q;
					res_vld_d     = 1'b1;
					res_d.count   = 7'(wr_q);
					res_d.removed = 7'(gone_q);
					res_d.status  = (gone_q == '0) ? clt_pkg::ST_NOTFOUND : clt_pkg::ST_OK;
					state_d       = clt_pkg::B_IDLE;
				end
			end
			clt_pkg::B_DUMP: begin
				re = (rd_q < count_q);
				if (re) begin
					rd_d = rd_inc;
				end
				if (vld_s1) begin
					res_vld_d     = 1'b1;
					res_d.element = rdata;
					res_d.is_last = last_s1;
					if (last_s1) begin
						state_d = clt_pkg::B_IDLE;
					end
				end
			end
			default: begin
				state_d = clt_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= clt_pkg::B_IDLE;
			count_q   <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			gone_q    <= '0;
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rd_q      <= rd_d;
			wr_q      <= wr_d;
			gone_q    <= gone_d;
			vld_s1    <= re;
			res_vld_q <= res_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q   <= val_d;
		all_q   <= all_d;
		last_s1 <= (rd_inc == count_q);
		res_q   <= res_d;
	end

	assign valid  = res_vld_q;
	assign result = res_q;

endmodule

`default_nettype wire

// File: hw/rtl/compacting_list_table_core.sv
// An ordered list of up to CAPACITY 64-bit words. A command is taken when
// start is high and busy is low; commands wait in a two-entry queue, and busy
// rises only when that queue is full. Each result appears for one cycle with
// valid high and cannot be held off. Append, overwrite and unused actions give
// one result each; a remove gives its result once its compaction scan has
// passed the whole list, and a dump gives one beat per entry, the last with
// is_last set (a single beat for an empty list). The back end takes no new
// command while a remove or dump is under way; both step through the list over
// the single read port of the list RAM, which visits one entry per cycle. No
// clearing pass follows reset.
// ----------------------------------------------------------------------------
// compacting_list_table_core
// Top level: command queue front end and list execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_list_table_core #(
	parameter int unsigned CAPACITY = clt_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire clt_pkg::in_t  cmd,
	output      logic          busy,
	output      logic          valid,
	output      clt_pkg::out_t result
);

	clt_pkg::q_link_t q_link;
	logic             pop;

	clt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.pop    (pop),
		.q_out  (q_link)
	);

	clt_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_in   (q_link),
		.pop    (pop),
		.valid  (valid),
		.result (result)
	);

endmodule

`default_nettype wire

// File: hw/rtl/clt_checker.sv
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks on the result stream of compacting_list_table_core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compacting_list_table_core_assert.svh"

module clt_checker #(
	parameter int unsigned CAPACITY = clt_pkg::CAPACITY_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          valid,
	input wire clt_pkg::out_t result
);

	// only a dump produces non-final beats, and those are always ok
	`CLT_ASSERT_SAME(a_mid_beat_ok, valid && !result.is_last, result.status == clt_pkg::ST_OK && result.removed == 7'd0, "non-final beat with bad status")

	// a dump streams without gaps until its last beat
	`CLT_ASSERT_NEXT(a_dump_no_gap, valid && !result.is_last, valid, "gap inside dump stream")

	`CLT_ASSERT_SAME(a_notfound_zero, valid && result.status == clt_pkg::ST_NOTFOUND, result.removed == 7'd0 && result.element == 64'd0, "not-found result with removals")

	`CLT_ASSERT_SAME(a_count_bound, valid, (8'(result.count) + 8'(result.removed)) <= 8'(CAPACITY), "count plus removed exceeds capacity")

endmodule

bind compacting_list_table_core clt_checker #(.CAPACITY(CAPACITY)) u_clt_checker (.*);

`default_nettype wire
